[design/backslash_escape_decoder_macros.svh]
// Assertion macros shared by the decoder modules.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef BACKSLASH_ESCAPE_DECODER_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge out of reset.
`define BED_ASSERT(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("backslash escape decoder: assertion failed");

// A condition that must hold in the same cycle as its trigger.
`define BED_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("backslash escape decoder: assertion failed");

// A condition that must hold in the cycle after its trigger.
`define BED_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("backslash escape decoder: assertion failed");

`else

`define BED_ASSERT(label, clk, rst_n, expr)
`define BED_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BED_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/bed_pkg.sv]
package bed_pkg;

	// Decoder modes.
	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_ESCAPE  = 3'd1,
		MODE_OCTAL   = 3'd2,
		MODE_HEX     = 3'd3,
		MODE_DISCARD = 3'd4
	} mode_t;

	// Character codes recognised by the decoder.
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_LC_A      = 8'h61;
	localparam logic [7:0] CH_LC_B      = 8'h62;
	localparam logic [7:0] CH_LC_C      = 8'h63;
	localparam logic [7:0] CH_LC_F      = 8'h66;
	localparam logic [7:0] CH_LC_N      = 8'h6E;
	localparam logic [7:0] CH_LC_R      = 8'h72;
	localparam logic [7:0] CH_LC_T      = 8'h74;
	localparam logic [7:0] CH_LC_V      = 8'h76;
	localparam logic [7:0] CH_LC_X      = 8'h78;

	// Control bytes produced by the simple escapes.
	localparam logic [7:0] CTL_BEL = 8'd7;
	localparam logic [7:0] CTL_BS  = 8'd8;
	localparam logic [7:0] CTL_FF  = 8'd12;
	localparam logic [7:0] CTL_LF  = 8'd10;
	localparam logic [7:0] CTL_CR  = 8'd13;
	localparam logic [7:0] CTL_HT  = 8'd9;
	localparam logic [7:0] CTL_VT  = 8'd11;

	// Digit limits of the numeric escapes.
	localparam logic [1:0] OCT_DIGITS_MAX = 2'd3;
	localparam logic [1:0] HEX_DIGITS_MAX = 2'd2;

	// Result queue.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Bytes produced by one decoded input beat.
	typedef struct packed {
		logic [1:0] count;
		logic [7:0] data0;
		logic [7:0] data1;
	} push_t;

endpackage

[design/bed_ifs.sv]
// Input channel: one text byte per beat.
interface bed_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       text_last;

	modport source (output valid, output text_byte, output text_last, input ready);
	modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

// Output channel: one decoded byte per beat.
interface bed_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

[design/bed_decode.sv]
`include "backslash_escape_decoder_macros.svh"

module bed_decode
	import bed_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bed_text_if.sink    text,
	input  logic        room,
	output logic        push_en,
	output push_t       push
);

	logic       valid_s1;
	logic [7:0] text_byte_s1;
	logic       text_last_s1;

	mode_t      mode_q, mode_d;
	logic [7:0] value_q, value_d;
	logic [1:0] count_q, count_d;

	logic       is_oct, is_hex, is_digit, full;
	logic [3:0] hex_val;
	logic [7:0] acc;
	logic [1:0] count_inc;

	// The input register empties whenever the queue can take two more bytes.
	assign push_en    = valid_s1 && room;
	assign text.ready = !valid_s1 || room;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (push_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			text_byte_s1 <= text.text_byte;
			text_last_s1 <= text.text_last;
		end
	end

	// Digit classification of the registered byte.
	always_comb begin
		is_oct  = text_byte_s1 inside {[8'h30:8'h37]};
		is_hex  = text_byte_s1 inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
		hex_val = (text_byte_s1 <= 8'h39) ? text_byte_s1[3:0] : (text_byte_s1[3:0] + 4'd9);
		is_digit  = (mode_q == MODE_OCTAL) ? is_oct : is_hex;
		acc       = (mode_q == MODE_OCTAL) ? {value_q[4:0], text_byte_s1[2:0]}
			: {value_q[3:0], hex_val};
		count_inc = count_q + 2'd1;
		full      = (mode_q == MODE_OCTAL) ? (count_inc >= OCT_DIGITS_MAX)
			: (count_inc >= HEX_DIGITS_MAX);
	end

	// Decode of one byte against the current mode.
	always_comb begin
		push    = '0;
		mode_d  = mode_q;
		value_d = value_q;
		count_d = count_q;
		case (mode_q)
			MODE_NORMAL: begin
				if (text_byte_s1 == CH_BACKSLASH && !text_last_s1) begin
					mode_d = MODE_ESCAPE;
				end else begin
					push.count = 2'd1;
					push.data0 = text_byte_s1;
				end
			end
			MODE_ESCAPE: begin
				mode_d     = MODE_NORMAL;
				push.count = 2'd1;
				case (text_byte_s1)
					CH_QUOTE, CH_BACKSLASH: push.data0 = text_byte_s1;
					CH_LC_A: push.data0 = CTL_BEL;
					CH_LC_B: push.data0 = CTL_BS;
					CH_LC_F: push.data0 = CTL_FF;
					CH_LC_N: push.data0 = CTL_LF;
					CH_LC_R: push.data0 = CTL_CR;
					CH_LC_T: push.data0 = CTL_HT;
					CH_LC_V: push.data0 = CTL_VT;
					CH_LC_C: begin
						mode_d     = MODE_DISCARD;
						push.count = 2'd0;
					end
					CH_LC_X: begin
						mode_d     = MODE_HEX;
						value_d    = 8'd0;
						count_d    = 2'd0;
						push.count = text_last_s1 ? 2'd1 : 2'd0;
						push.data0 = 8'd0;
					end
					default: begin
						if (is_oct) begin
							mode_d     = MODE_OCTAL;
							value_d    = {5'd0, text_byte_s1[2:0]};
							count_d    = 2'd1;
							push.count = text_last_s1 ? 2'd1 : 2'd0;
							push.data0 = {5'd0, text_byte_s1[2:0]};
						end else begin
							push.count = 2'd2;
							push.data0 = CH_BACKSLASH;
							push.data1 = text_byte_s1;
						end
					end
				endcase
			end
			MODE_OCTAL, MODE_HEX: begin
				if (is_digit) begin
					value_d = acc;
					count_d = count_inc;
					if (full || text_last_s1) begin
						mode_d     = MODE_NORMAL;
						push.count = 2'd1;
						push.data0 = acc;
					end
				end else begin
					// A non-digit flushes the value and is then decoded as plain text.
					push.data0 = value_q;
					if (text_byte_s1 == CH_BACKSLASH && !text_last_s1) begin
						mode_d     = MODE_ESCAPE;
						push.count = 2'd1;
					end else begin
						mode_d     = MODE_NORMAL;
						push.count = 2'd2;
						push.data1 = text_byte_s1;
					end
				end
			end
			MODE_DISCARD: begin
				push.count = 2'd0;
			end
			default: begin
				mode_d = MODE_NORMAL;
			end
		endcase

		// The end of the text returns the decoder to its reset state.
		if (text_last_s1) begin
			mode_d  = MODE_NORMAL;
			value_d = 8'd0;
			count_d = 2'd0;
		end
	end

	// Decoder state advances with each decoded beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			value_q <= 8'd0;
			count_q <= 2'd0;
		end else if (push_en) begin
			mode_q  <= mode_d;
			value_q <= value_d;
			count_q <= count_d;
		end
	end

	`BED_ASSERT_IMP(a_discard_silent, clk, arst_n, push_en && mode_q == MODE_DISCARD, push.count == 2'd0)
	`BED_ASSERT_NXT(a_last_resets, clk, arst_n, push_en && text_last_s1, mode_q == MODE_NORMAL && count_q == 2'd0)
	`BED_ASSERT_IMP(a_two_only_no_escape, clk, arst_n, push_en && push.count == 2'd2, mode_d == MODE_NORMAL)

endmodule

[design/bed_out_queue.sv]
`include "backslash_escape_decoder_macros.svh"

module bed_out_queue
	import bed_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_en,
	input  push_t       push,
	output logic        room,
	bed_byte_if.source  result
);

	logic [7:0]        data_q [QDEPTH];
	logic              last_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_1;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	// Space for the largest burst of one beat, judged on the registered fill level.
	assign room     = count_q <= QCNT_W'(QDEPTH - 2);
	assign pop      = result.valid && result.ready;
	assign wr_ptr_1 = wr_ptr_q + QPTR_W'(1);

	assign result.valid    = count_q != '0;
	assign result.out_byte = data_q[rd_ptr_q];
	assign result.run_last = last_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (push_en ? QCNT_W'(push.count) : '0) - QCNT_W'(pop);
		end
	end

	// Entry storage; the final byte of a beat carries the last mark.
	always_ff @(posedge clk) begin
		if (push_en && push.count != 2'd0) begin
			data_q[wr_ptr_q] <= push.data0;
			last_q[wr_ptr_q] <= (push.count == 2'd1);
		end
		if (push_en && push.count == 2'd2) begin
			data_q[wr_ptr_1] <= push.data1;
			last_q[wr_ptr_1] <= 1'b1;
		end
	end

	`BED_ASSERT(a_no_overflow, clk, arst_n, count_q <= QCNT_W'(QDEPTH))
	`BED_ASSERT_IMP(a_push_fits, clk, arst_n, push_en, count_q <= QCNT_W'(QDEPTH - 2))
	`BED_ASSERT_NXT(a_drain_step, clk, arst_n, pop && !push_en, count_q == $past(count_q) - QCNT_W'(1))

endmodule

[design/backslash_escape_decoder.sv]
// Backslash escape decoder.
// The text channel takes one byte of text per beat, with text_last marking the
// final byte of a text. The result channel gives the decoded bytes, one per beat;
// run_last marks the final byte caused by one text beat. A text beat gives no,
// one or two result bytes.
// A byte accepted from the text channel is held in the input register, decoded
// from it combinationally and stored in a four-entry result queue; its first
// result byte is offered once it is in the queue.
// Throughput: one text beat per cycle while each beat gives at most one byte and
// the receiver does not stall; beats that give two bytes fill the queue until the
// input register holds off. The input register advances only while the queue
// holds at most two bytes.
// Reset clears the decoder to plain text mode and empties the queue. When the
// receiver stalls, the queue fills, then the input register holds its byte and
// the text channel drops ready; no byte is lost or repeated.
module backslash_escape_decoder
	import bed_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bed_text_if.sink    text,
	bed_byte_if.source  result
);

	logic  room;
	logic  push_en;
	push_t push;

	bed_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text),
		.room    (room),
		.push_en (push_en),
		.push    (push)
	);

	bed_out_queue u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_en (push_en),
		.push    (push),
		.room    (room),
		.result  (result)
	);

endmodule

[tb/tb_backslash_escape_decoder.sv]
`timescale 1ns / 1ps

module tb_backslash_escape_decoder
	import bed_pkg::*;
();

	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 20;
	localparam int RANDOM_BEATS = 380;

	typedef struct {
		logic [7:0] tbyte;
		logic       tlast;
		int         phase;
	} text_beat_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} decoded_byte_t;

	// Idle percentages per traffic phase: receiver slow, sender slow, then none.
	int send_idle_pct [3] = '{27, 70, 0};
	int recv_idle_pct [3] = '{70, 27, 0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       txn_valid = 1'b0;
	logic [7:0] txn_byte = 8'h00;
	logic       txn_last = 1'b0;
	logic       rx_ready = 1'b0;

	text_beat_t    text_pending [$];
	decoded_byte_t expected_bytes [$];
	logic [7:0]    beat_bytes [$];
	text_beat_t    drive_beat;
	decoded_byte_t exp_res;
	int            traffic_phase = 0;
	int            err_cnt = 0;
	int            cycle_cnt = 0;

	// Predictor state.
	mode_t      dec_mode = MODE_NORMAL;
	logic [7:0] dec_value = 8'h00;
	logic [1:0] dec_digits = 2'd0;

	bed_text_if text_ch ();
	bed_byte_if result_ch ();

	assign text_ch.valid     = txn_valid;
	assign text_ch.text_byte = txn_byte;
	assign text_ch.text_last = txn_last;
	assign result_ch.ready   = rx_ready;

	backslash_escape_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Value of a digit or letter, or -1 for anything else.
	function automatic int digit_of(input logic [7:0] b);
		if (b >= "0" && b <= "9") return int'(b) - int'("0");
		if (b >= "A" && b <= "Z") return int'(b) - int'("A") + 10;
		if (b >= "a" && b <= "z") return int'(b) - int'("a") + 10;
		return -1;
	endfunction

	// Ordinary text: a backslash opens an escape unless it ends the text.
	task automatic take_plain(input logic [7:0] b, input logic last);
		if (b == CH_BACKSLASH && !last) begin
			dec_mode = MODE_ESCAPE;
		end else begin
			beat_bytes.push_back(b);
		end
	endtask

	// One byte inside an octal or hex escape.
	task automatic take_digit(input logic [7:0] b, input logic last, input int radix,
			input int shift, input logic [1:0] maxd);
		int d;
		d = digit_of(b);
		if (d >= 0 && d < radix) begin
			dec_value = 8'((dec_value << shift) | d);
			dec_digits = dec_digits + 2'd1;
			if (dec_digits >= maxd || last) begin
				beat_bytes.push_back(dec_value);
				dec_mode = MODE_NORMAL;
			end
		end else begin
			beat_bytes.push_back(dec_value);
			dec_mode = MODE_NORMAL;
			take_plain(b, last);
		end
	endtask

	// Works out the decoded bytes caused by one accepted text beat.
	task automatic decode_text_beat(input logic [7:0] b, input logic last);
		decoded_byte_t r;
		beat_bytes.delete();
		case (dec_mode)
			MODE_ESCAPE: begin
				dec_mode = MODE_NORMAL;
				case (b)
					CH_QUOTE, CH_BACKSLASH: beat_bytes.push_back(b);
					CH_LC_A: beat_bytes.push_back(CTL_BEL);
					CH_LC_B: beat_bytes.push_back(CTL_BS);
					CH_LC_F: beat_bytes.push_back(CTL_FF);
					CH_LC_N: beat_bytes.push_back(CTL_LF);
					CH_LC_R: beat_bytes.push_back(CTL_CR);
					CH_LC_T: beat_bytes.push_back(CTL_HT);
					CH_LC_V: beat_bytes.push_back(CTL_VT);
					CH_LC_C: dec_mode = MODE_DISCARD;
					CH_LC_X: begin
						dec_value = 8'h00;
						dec_digits = 2'd0;
						dec_mode = MODE_HEX;
						if (last) beat_bytes.push_back(8'h00);
					end
					default: begin
						if (b >= "0" && b <= "7") begin
							dec_value = b - 8'("0");
							dec_digits = 2'd1;
							dec_mode = MODE_OCTAL;
							if (last) beat_bytes.push_back(dec_value);
						end else begin
							beat_bytes.push_back(CH_BACKSLASH);
							beat_bytes.push_back(b);
						end
					end
				endcase
			end
			MODE_OCTAL: take_digit(b, last, 8, 3, OCT_DIGITS_MAX);
			MODE_HEX: take_digit(b, last, 16, 4, HEX_DIGITS_MAX);
			MODE_DISCARD: ;
			default: take_plain(b, last);
		endcase
		foreach (beat_bytes[i]) begin
			r.data = beat_bytes[i];
			r.last = (i == beat_bytes.size() - 1);
			expected_bytes.push_back(r);
		end
		// The end of a text returns the decoder to its reset state.
		if (last) begin
			dec_mode = MODE_NORMAL;
			dec_value = 8'h00;
			dec_digits = 2'd0;
		end
	endtask

	task automatic push_beat(input logic [7:0] b, input logic last);
		text_beat_t t;
		t.tbyte = b;
		t.tlast = last;
		t.phase = 0;
		text_pending.push_back(t);
	endtask

	task automatic push_text(input string s, input logic end_text);
		for (int i = 0; i < s.len(); i++) begin
			push_beat(s[i], end_text && (i == s.len() - 1));
		end
	endtask

	// One random text built mostly from well-formed escapes, with some noise.
	task automatic push_random_text();
		string simple_esc;
		string hex_ch;
		logic [7:0] bytes [$];
		int tokens;
		int kind;
		int ndig;
		logic end_text;
		simple_esc = "\\\"abfnrtv";
		hex_ch = "0123456789abcdefABCDEF";
		tokens = $urandom_range(1, 8);
		for (int t = 0; t < tokens; t++) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				if ($urandom_range(0, 1)) bytes.push_back(8'($urandom_range(32, 126)));
				else bytes.push_back(8'($urandom_range(0, 255)));
			end else if (kind < 45) begin
				bytes.push_back(CH_BACKSLASH);
				bytes.push_back(simple_esc[$urandom_range(0, simple_esc.len() - 1)]);
			end else if (kind < 60) begin
				bytes.push_back(CH_BACKSLASH);
				ndig = $urandom_range(1, 4);
				for (int i = 0; i < ndig; i++) bytes.push_back(8'("0") + 8'($urandom_range(0, 7)));
			end else if (kind < 75) begin
				bytes.push_back(CH_BACKSLASH);
				bytes.push_back(CH_LC_X);
				ndig = $urandom_range(0, 3);
				for (int i = 0; i < ndig; i++) bytes.push_back(hex_ch[$urandom_range(0, 21)]);
				if ($urandom_range(0, 3) == 0) bytes.push_back(8'("g"));
			end else if (kind < 83) begin
				bytes.push_back(CH_BACKSLASH);
				bytes.push_back(8'($urandom_range(0, 255)));
			end else if (kind < 87) begin
				bytes.push_back(CH_BACKSLASH);
				bytes.push_back(CH_LC_C);
			end else if (kind < 93) begin
				bytes.push_back(8'("%"));
			end else begin
				bytes.push_back(8'h00);
			end
		end
		if ($urandom_range(0, 9) == 0) bytes.push_back(CH_BACKSLASH);
		// A text left open now and then carries its state into the next one.
		end_text = ($urandom_range(0, 9) != 0);
		foreach (bytes[i]) push_beat(bytes[i], end_text && (i == bytes.size() - 1));
	endtask

	// Stimulus, reset and the end of the run.
	initial begin
		int total;
		int directed;
		push_beat(8'h00, 1'b0);
		push_beat(8'hFF, 1'b0);
		push_text("%", 1'b1);
		push_text("\\n\\t\\\\\\\"\\q", 1'b1);
		push_text("\\101\\377\\18", 1'b0);
		push_text("\\7", 1'b1);
		push_text("\\x4fz\\xg", 1'b0);
		push_text("\\x", 1'b1);
		push_text("\\cab", 1'b1);
		push_text("\\", 1'b1);
		directed = text_pending.size();
		while (text_pending.size() < directed + RANDOM_BEATS) push_random_text();
		total = text_pending.size();
		foreach (text_pending[i]) text_pending[i].phase = (i * 3) / total;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (!(text_pending.size() == 0 && !txn_valid && expected_bytes.size() == 0))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Text driver: offers pending beats and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txn_valid <= 1'b0;
			txn_byte <= 8'h00;
			txn_last <= 1'b0;
		end else begin
			if (txn_valid && text_ch.ready) decode_text_beat(txn_byte, txn_last);
			if (!txn_valid || text_ch.ready) begin
				if (text_pending.size() > 0 &&
						$urandom_range(0, 99) >= send_idle_pct[text_pending[0].phase]) begin
					drive_beat = text_pending.pop_front();
					traffic_phase <= drive_beat.phase;
					txn_valid <= 1'b1;
					txn_byte <= drive_beat.tbyte;
					txn_last <= drive_beat.tlast;
				end else begin
					txn_valid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_mismatch(input string what);
		err_cnt++;
		$display("cycle %0d: result mismatch: %s", cycle_cnt, what);
	endtask

	// Result monitor: compares each accepted beat with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ready <= 1'b0;
		end else begin
			if (result_ch.valid && rx_ready) begin
				if (expected_bytes.size() == 0) begin
					flag_mismatch($sformatf("unexpected byte %02h last %0b",
						result_ch.out_byte, result_ch.run_last));
				end else begin
					exp_res = expected_bytes.pop_front();
					if (result_ch.out_byte !== exp_res.data)
						flag_mismatch($sformatf("out_byte %02h, expected %02h",
							result_ch.out_byte, exp_res.data));
					if (result_ch.run_last !== exp_res.last)
						flag_mismatch($sformatf("run_last %0b, expected %0b",
							result_ch.run_last, exp_res.last));
				end
			end
			rx_ready <= ($urandom_range(0, 99) >= recv_idle_pct[traffic_phase]);
		end
	end

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

[files.f]
+incdir+design
design/bed_pkg.sv
design/bed_ifs.sv
design/bed_decode.sv
design/bed_out_queue.sv
design/backslash_escape_decoder.sv
tb/tb_backslash_escape_decoder.sv
